// ----- rtl/rcd_pkg.sv -----
// ----------------------------------------------------------------------------
// rcd_pkg
// Types, codes and name tables shared by the command line decoder modules.
// ----------------------------------------------------------------------------
`default_nettype none

package rcd_pkg;

    // Kind of header seen in the first token of a line.
    typedef enum logic [1:0] {
        HDR_UNKNOWN = 2'd0,
        HDR_CMD     = 2'd1,
        HDR_PID     = 2'd2,
        HDR_MOD     = 2'd3
    } hdr_t;

    // Line kind reported with every result word.
    typedef enum logic [2:0] {
        KIND_CMD     = 3'd0,
        KIND_PID     = 3'd1,
        KIND_MOD     = 3'd2,
        KIND_UNKNOWN = 3'd3,
        KIND_DISCARD = 3'd4
    } kind_t;

    // Key selected by the odd token of a CMD pair.
    typedef enum logic [2:0] {
        KEY_NONE = 3'd0,
        KEY_T    = 3'd1,
        KEY_R    = 3'd2,
        KEY_P    = 3'd3,
        KEY_Y    = 3'd4,
        KEY_H    = 3'd5
    } key_t;

    // Number scanner phase inside a token.
    typedef enum logic [1:0] {
        PH_SPACE = 2'd0,
        PH_DIGIT = 2'd1,
        PH_DONE  = 2'd2
    } phase_t;

    // Flight mode codes.
    localparam logic [2:0] MODE_BLOCK    = 3'd0;
    localparam logic [2:0] MODE_MANUAL   = 3'd1;
    localparam logic [2:0] MODE_ALTITUDE = 3'd2;
    localparam logic [2:0] MODE_GPS      = 3'd3;
    localparam logic [2:0] MODE_HOME     = 3'd4;

    // Mode notice codes.
    localparam logic [1:0] NOTE_NONE  = 2'd0;
    localparam logic [1:0] NOTE_ARMED = 2'd1;
    localparam logic [1:0] NOTE_BLOCK = 2'd2;

    // Configuration register indexes.
    localparam logic [2:0] REG_STICK_MIN   = 3'd0;
    localparam logic [2:0] REG_STICK_MAX   = 3'd1;
    localparam logic [2:0] REG_THRUST_IDLE = 3'd2;
    localparam logic [2:0] REG_YAW_ARM     = 3'd3;
    localparam logic [2:0] REG_YAW_BLOCK   = 3'd4;

    // Special characters.
    localparam logic [7:0] CH_NEWLINE = 8'd10;
    localparam logic [7:0] CH_COMMA   = 8'd44;
    localparam logic [7:0] CH_NUL     = 8'd0;

    // Names that a token can match.
    localparam int NM_CMD      = 0;
    localparam int NM_PID      = 1;
    localparam int NM_MOD      = 2;
    localparam int NM_T        = 3;
    localparam int NM_R        = 4;
    localparam int NM_P        = 5;
    localparam int NM_Y        = 6;
    localparam int NM_H        = 7;
    localparam int NM_MANUAL   = 8;
    localparam int NM_ALTITUDE = 9;
    localparam int NM_GPS      = 10;
    localparam int NM_HOME     = 11;
    localparam int NAME_COUNT  = 12;

    // Status of the token being collected.
    typedef struct packed {
        logic [NAME_COUNT-1:0] hit;      // exact match for each name
        logic                  short_ok; // shorter than the token buffer
        logic                  nonempty;
        logic                  first_t;  // first character is 'T'
        logic                  neg;
        logic [15:0]           mag;
    } tok_stat_t;

    // Text of a name, right justified, last character in the low byte.
    function automatic logic [63:0] name_text(input int unsigned id);
        logic [63:0] t;
        t = '0;
        case (id)
            NM_CMD:      t = 64'("CMD");
            NM_PID:      t = 64'("PID");
            NM_MOD:      t = 64'("MOD");
            NM_T:        t = 64'("T");
            NM_R:        t = 64'("R");
            NM_P:        t = 64'("P");
            NM_Y:        t = 64'("Y");
            NM_H:        t = 64'("H");
            NM_MANUAL:   t = 64'("MANUAL");
            NM_ALTITUDE: t = 64'("ALTITUDE");
            NM_GPS:      t = 64'("GPS");
            NM_HOME:     t = 64'("HOME");
            default:     t = '0;
        endcase
        return t;
    endfunction

    function automatic logic [3:0] name_len(input int unsigned id);
        logic [3:0] n;
        n = 4'd0;
        case (id)
            NM_CMD, NM_PID, NM_MOD, NM_GPS:   n = 4'd3;
            NM_T, NM_R, NM_P, NM_Y, NM_H:     n = 4'd1;
            NM_MANUAL:                        n = 4'd6;
            NM_ALTITUDE:                      n = 4'd8;
            NM_HOME:                          n = 4'd4;
            default:                          n = 4'd0;
        endcase
        return n;
    endfunction

    // Character at a position of a name; only meaningful below its length.
    function automatic logic [7:0] name_char(input int unsigned id, input logic [2:0] pos);
        logic [2:0]  back;
        logic [63:0] t;
        t    = name_text(id);
        back = 3'(name_len(id) - 4'd1) - pos;
        return t[{back, 3'b000} +: 8];
    endfunction

endpackage

`default_nettype wire

// ----- rtl/rc_command_line_decoder.sv -----
// ----------------------------------------------------------------------------
// rc_command_line_decoder
// Decodes newline ended, comma separated remote control command lines.
// ----------------------------------------------------------------------------
// The block takes one received byte in every cycle and gives one result word
// for each newline, in the cycle after that newline is taken; other bytes give
// none. All parsing is incremental: each byte updates the token matcher and
// the decimal accumulator (one multiply by ten and add), and a newline
// resolves the line in the same cycle. The input stalls only while a result
// waits in the output register and the output side stalls it.
`default_nettype none

module rc_command_line_decoder #(
    parameter int MAX_LINE    = 64,
    parameter int MAX_TOKENS  = 12,
    parameter int TOKEN_CHARS = 16
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        cfg_write,
    input  wire logic [2:0]  cfg_index,
    input  wire logic [15:0] cfg_data,
    input  wire logic        in_valid,
    output logic             in_stall,
    input  wire logic [7:0]  rx_byte,
    output logic             out_valid,
    input  wire logic        out_stall,
    output logic [2:0]       line_kind,
    output logic [15:0]      thrust,
    output logic [15:0]      roll,
    output logic [15:0]      pitch,
    output logic [15:0]      yaw,
    output logic             heading_lock,
    output logic [2:0]       flight_mode,
    output logic [1:0]       mode_notice
);

    localparam int LLW = $clog2(MAX_LINE + 1);
    localparam int TNW = $clog2(MAX_TOKENS + 1);

    // Configuration registers.
    logic [15:0] stick_min_reg, stick_max_reg, idle_reg, yaw_arm_reg, yaw_block_reg;

    // Line parser state.
    logic [LLW-1:0]  line_len_reg, line_len_next;
    logic [TNW-1:0]  tok_num_reg, tok_num_next;
    rcd_pkg::hdr_t   hdr_reg, hdr_next;
    rcd_pkg::key_t   key_reg, key_next;
    logic            cut_reg, cut_next;
    logic [15:0]     pend_stick_reg [4];
    logic [15:0]     pend_stick_next [4];
    logic            pend_head_reg, pend_head_next;
    logic [2:0]      pend_mode_reg, pend_mode_next;

    // Stored values.
    logic [15:0]     stick_reg [4];
    logic [15:0]     stick_next [4];
    logic            head_reg, head_next;
    logic [2:0]      mode_reg, mode_next;

    // Result register.
    logic            out_valid_reg;
    rcd_pkg::kind_t  kind_reg, kind_next;
    logic [1:0]      note_reg, note_next;
    logic            emit;

    // Token collector.
    rcd_pkg::tok_stat_t tok;
    logic               tok_load;
    logic               tok_clear;
    logic               accept;
    logic               is_nl;
    logic               finish;
    logic               stick_ok;

    assign in_stall = out_valid_reg && out_stall;
    assign accept   = in_valid && !in_stall;
    assign is_nl    = (rx_byte == rcd_pkg::CH_NEWLINE);

    assign finish    = accept && !cut_reg && tok.nonempty &&
                       (is_nl || rx_byte == rcd_pkg::CH_NUL || rx_byte == rcd_pkg::CH_COMMA);
    assign tok_load  = accept && !cut_reg && !is_nl &&
                       rx_byte != rcd_pkg::CH_NUL && rx_byte != rcd_pkg::CH_COMMA;
    assign tok_clear = finish || (accept && is_nl);

    assign stick_ok = tok.short_ok && !(tok.neg && tok.mag != 16'd0) &&
                      tok.mag >= stick_min_reg && tok.mag <= stick_max_reg;

    rcd_token #(
        .TOKEN_CHARS (TOKEN_CHARS)
    ) u_token (
        .clk   (clk),
        .rst_n (rst_n),
        .load  (tok_load),
        .clear (tok_clear),
        .ch    (rx_byte),
        .stat  (tok)
    );

    // Byte and line processing.
    always_comb
    begin
        line_len_next   = line_len_reg;
        tok_num_next    = tok_num_reg;
        hdr_next        = hdr_reg;
        key_next        = key_reg;
        cut_next        = cut_reg;
        pend_stick_next = pend_stick_reg;
        pend_head_next  = pend_head_reg;
        pend_mode_next  = pend_mode_reg;
        stick_next      = stick_reg;
        head_next       = head_reg;
        mode_next       = mode_reg;
        kind_next       = kind_reg;
        note_next       = rcd_pkg::NOTE_NONE;
        emit            = 1'b0;

        // Close the current token.
        if (finish && int'(tok_num_reg) < MAX_TOKENS)
        begin
            if (tok_num_reg == '0)
            begin
                if (tok.hit[rcd_pkg::NM_CMD])
                    hdr_next = rcd_pkg::HDR_CMD;
                else if (tok.hit[rcd_pkg::NM_PID])
                    hdr_next = rcd_pkg::HDR_PID;
                else if (tok.hit[rcd_pkg::NM_MOD])
                    hdr_next = rcd_pkg::HDR_MOD;
                else
                    hdr_next = rcd_pkg::HDR_UNKNOWN;
            end
            else if (hdr_reg == rcd_pkg::HDR_CMD)
            begin
                if (tok_num_reg[0])
                begin
                    if (tok.hit[rcd_pkg::NM_T])
                        key_next = rcd_pkg::KEY_T;
                    else if (tok.hit[rcd_pkg::NM_R])
                        key_next = rcd_pkg::KEY_R;
                    else if (tok.hit[rcd_pkg::NM_P])
                        key_next = rcd_pkg::KEY_P;
                    else if (tok.hit[rcd_pkg::NM_Y])
                        key_next = rcd_pkg::KEY_Y;
                    else if (tok.hit[rcd_pkg::NM_H])
                        key_next = rcd_pkg::KEY_H;
                    else
                        key_next = rcd_pkg::KEY_NONE;
                end
                else
                begin
                    case (key_reg)
                        rcd_pkg::KEY_T: if (stick_ok) pend_stick_next[0] = tok.mag;
                        rcd_pkg::KEY_R: if (stick_ok) pend_stick_next[1] = tok.mag;
                        rcd_pkg::KEY_P: if (stick_ok) pend_stick_next[2] = tok.mag;
                        rcd_pkg::KEY_Y: if (stick_ok) pend_stick_next[3] = tok.mag;
                        rcd_pkg::KEY_H: pend_head_next = tok.first_t;
                        default:        pend_head_next = pend_head_reg;
                    endcase
                    key_next = rcd_pkg::KEY_NONE;
                end
            end
            else if (hdr_reg == rcd_pkg::HDR_MOD && tok_num_reg == TNW'(1))
            begin
                if (tok.hit[rcd_pkg::NM_MANUAL])
                    pend_mode_next = rcd_pkg::MODE_MANUAL;
                else if (tok.hit[rcd_pkg::NM_ALTITUDE])
                    pend_mode_next = rcd_pkg::MODE_ALTITUDE;
                else if (tok.hit[rcd_pkg::NM_GPS])
                    pend_mode_next = rcd_pkg::MODE_GPS;
                else if (tok.hit[rcd_pkg::NM_HOME])
                    pend_mode_next = rcd_pkg::MODE_HOME;
            end
            tok_num_next = tok_num_reg + TNW'(1);
        end

        if (accept && !is_nl)
        begin
            // Count the byte; a zero byte ends the text of the line.
            if (int'(line_len_reg) < MAX_LINE)
                line_len_next = line_len_reg + LLW'(1);
            if (!cut_reg && rx_byte == rcd_pkg::CH_NUL)
                cut_next = 1'b1;
        end
        else if (accept)
        begin
            // Resolve the line.
            emit = 1'b1;
            if (line_len_reg == '0 || int'(line_len_reg) >= MAX_LINE)
            begin
                kind_next = rcd_pkg::KIND_DISCARD;
            end
            else if (tok_num_next == '0 || hdr_next == rcd_pkg::HDR_UNKNOWN)
            begin
                kind_next = rcd_pkg::KIND_UNKNOWN;
            end
            else if (hdr_next == rcd_pkg::HDR_PID)
            begin
                kind_next = rcd_pkg::KIND_PID;
            end
            else if (hdr_next == rcd_pkg::HDR_MOD)
            begin
                kind_next = rcd_pkg::KIND_MOD;
                mode_next = pend_mode_next;
            end
            else
            begin
                kind_next  = rcd_pkg::KIND_CMD;
                stick_next = pend_stick_next;
                head_next  = pend_head_next;
                if (pend_stick_next[0] < idle_reg && pend_stick_next[3] < yaw_arm_reg &&
                    mode_reg == rcd_pkg::MODE_BLOCK)
                begin
                    mode_next = rcd_pkg::MODE_MANUAL;
                    note_next = rcd_pkg::NOTE_ARMED;
                end
                else if (pend_stick_next[0] < idle_reg && pend_stick_next[3] > yaw_block_reg &&
                         mode_reg != rcd_pkg::MODE_BLOCK)
                begin
                    mode_next = rcd_pkg::MODE_BLOCK;
                    note_next = rcd_pkg::NOTE_BLOCK;
                end
            end

            // Start the next line from the stored values.
            line_len_next   = '0;
            tok_num_next    = '0;
            hdr_next        = rcd_pkg::HDR_UNKNOWN;
            key_next        = rcd_pkg::KEY_NONE;
            cut_next        = 1'b0;
            pend_stick_next = stick_next;
            pend_head_next  = head_next;
            pend_mode_next  = mode_next;
        end
    end

    // Parser and stored state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            line_len_reg  <= '0;
            tok_num_reg   <= '0;
            hdr_reg       <= rcd_pkg::HDR_UNKNOWN;
            key_reg       <= rcd_pkg::KEY_NONE;
            cut_reg       <= 1'b0;
            pend_head_reg <= 1'b0;
            pend_mode_reg <= rcd_pkg::MODE_BLOCK;
            head_reg      <= 1'b0;
            mode_reg      <= rcd_pkg::MODE_BLOCK;
            for (int i = 0; i < 4; i++)
            begin
                pend_stick_reg[i] <= '0;
                stick_reg[i]      <= '0;
            end
        end
        else
        begin
            line_len_reg   <= line_len_next;
            tok_num_reg    <= tok_num_next;
            hdr_reg        <= hdr_next;
            key_reg        <= key_next;
            cut_reg        <= cut_next;
            pend_stick_reg <= pend_stick_next;
            pend_head_reg  <= pend_head_next;
            pend_mode_reg  <= pend_mode_next;
            stick_reg      <= stick_next;
            head_reg       <= head_next;
            mode_reg       <= mode_next;
        end
    end

    // Configuration writes.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stick_min_reg <= 16'd1000;
            stick_max_reg <= 16'd2000;
            idle_reg      <= 16'd1030;
            yaw_arm_reg   <= 16'd1080;
            yaw_block_reg <= 16'd1900;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                rcd_pkg::REG_STICK_MIN:   stick_min_reg <= cfg_data;
                rcd_pkg::REG_STICK_MAX:   stick_max_reg <= cfg_data;
                rcd_pkg::REG_THRUST_IDLE: idle_reg      <= cfg_data;
                rcd_pkg::REG_YAW_ARM:     yaw_arm_reg   <= cfg_data;
                rcd_pkg::REG_YAW_BLOCK:   yaw_block_reg <= cfg_data;
                default:                  idle_reg      <= idle_reg;
            endcase
        end
    end

    // Result register valid flag.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (emit)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    // Result payload, loaded only with a new result.
    always_ff @(posedge clk)
    begin
        if (emit)
        begin
            kind_reg <= kind_next;
            note_reg <= note_next;
        end
    end

    // The stored values only change when a result is loaded.
    assign out_valid    = out_valid_reg;
    assign line_kind    = kind_reg;
    assign thrust       = stick_reg[0];
    assign roll         = stick_reg[1];
    assign pitch        = stick_reg[2];
    assign yaw          = stick_reg[3];
    assign heading_lock = head_reg;
    assign flight_mode  = mode_reg;
    assign mode_notice  = note_reg;

endmodule

`default_nettype wire

// ----- rtl/rcd_token.sv -----
// ----------------------------------------------------------------------------
// rcd_token
// Collects one comma separated token a character at a time: tracks its
// length, matches it against every known name and scans it as a number.
// ----------------------------------------------------------------------------
`default_nettype none

module rcd_token #(
    parameter int TOKEN_CHARS = 16
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              load,
    input  wire logic              clear,
    input  wire logic [7:0]        ch,
    output rcd_pkg::tok_stat_t     stat
);

    localparam int LW = $clog2(TOKEN_CHARS + 1);

    logic [LW-1:0]                    len_reg, len_next;
    logic [rcd_pkg::NAME_COUNT-1:0]   pre_reg, pre_next;
    logic                             first_t_reg, first_t_next;
    logic                             neg_reg, neg_next;
    logic [15:0]                      mag_reg, mag_next;
    rcd_pkg::phase_t                  phase_reg, phase_next;

    logic        store;
    logic        is_space;
    logic        is_digit;
    logic [3:0]  digit;
    logic [19:0] acc;

    assign store    = load && (int'(len_reg) < TOKEN_CHARS);
    assign is_space = (ch == 8'd32) || (ch >= 8'd9 && ch <= 8'd13);
    assign is_digit = (ch >= "0") && (ch <= "9");
    assign digit    = 4'(ch - "0");
    assign acc      = {1'b0, mag_reg, 3'b000} + {3'b000, mag_reg, 1'b0} + {16'd0, digit};

    // Next token state.
    always_comb
    begin
        len_next     = len_reg;
        pre_next     = pre_reg;
        first_t_next = first_t_reg;
        neg_next     = neg_reg;
        mag_next     = mag_reg;
        phase_next   = phase_reg;
        if (clear)
        begin
            len_next     = '0;
            pre_next     = '1;
            first_t_next = 1'b0;
            neg_next     = 1'b0;
            mag_next     = '0;
            phase_next   = rcd_pkg::PH_SPACE;
        end
        else if (store)
        begin
            len_next = len_reg + LW'(1);
            for (int i = 0; i < rcd_pkg::NAME_COUNT; i++)
            begin
                pre_next[i] = pre_reg[i] && (int'(len_reg) < int'(rcd_pkg::name_len(i)))
                              && (ch == rcd_pkg::name_char(i, len_reg[2:0]));
            end
            if (len_reg == '0)
            begin
                first_t_next = (ch == "T");
            end
            case (phase_reg)
                rcd_pkg::PH_SPACE:
                begin
                    if (is_space)
                    begin
                        phase_next = rcd_pkg::PH_SPACE;
                    end
                    else if (ch == "+" || ch == "-")
                    begin
                        neg_next   = (ch == "-");
                        phase_next = rcd_pkg::PH_DIGIT;
                    end
                    else if (is_digit)
                    begin
                        mag_next   = {12'd0, digit};
                        phase_next = rcd_pkg::PH_DIGIT;
                    end
                    else
                    begin
                        phase_next = rcd_pkg::PH_DONE;
                    end
                end
                rcd_pkg::PH_DIGIT:
                begin
                    if (is_digit)
                    begin
                        mag_next = (acc > 20'd65535) ? 16'hFFFF : acc[15:0];
                    end
                    else
                    begin
                        phase_next = rcd_pkg::PH_DONE;
                    end
                end
                default:
                begin
                    phase_next = rcd_pkg::PH_DONE;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            len_reg     <= '0;
            pre_reg     <= '1;
            first_t_reg <= 1'b0;
            neg_reg     <= 1'b0;
            mag_reg     <= '0;
            phase_reg   <= rcd_pkg::PH_SPACE;
        end
        else
        begin
            len_reg     <= len_next;
            pre_reg     <= pre_next;
            first_t_reg <= first_t_next;
            neg_reg     <= neg_next;
            mag_reg     <= mag_next;
            phase_reg   <= phase_next;
        end
    end

    // Token status; a name hits only on an exact length inside the buffer.
    always_comb
    begin
        stat.short_ok = int'(len_reg) < TOKEN_CHARS;
        stat.nonempty = (len_reg != '0);
        stat.first_t  = first_t_reg;
        stat.neg      = neg_reg;
        stat.mag      = mag_reg;
        for (int i = 0; i < rcd_pkg::NAME_COUNT; i++)
        begin
            stat.hit[i] = pre_reg[i] && (int'(len_reg) == int'(rcd_pkg::name_len(i)))
                          && (int'(len_reg) < TOKEN_CHARS);
        end
    end

endmodule

`default_nettype wire

// ----- rtl/rcd_checker.sv -----
// ----------------------------------------------------------------------------
// rcd_checker
// Port level checks of the command line decoder, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module rcd_checker (
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        in_stall,
    input wire logic        out_valid,
    input wire logic        out_stall,
    input wire logic [2:0]  line_kind,
    input wire logic [2:0]  flight_mode,
    input wire logic [1:0]  mode_notice
);

    // A held result keeps its line kind and mode notice.
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(line_kind) && $stable(mode_notice))
        else $error("held result changed");

    // Input stalls only behind a waiting result.
    a_stall: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> out_valid && out_stall)
        else $error("input stalled without a waiting result");

    // A mode notice only comes with a decoded CMD line.
    a_note_cmd: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && mode_notice != rcd_pkg::NOTE_NONE |-> line_kind == rcd_pkg::KIND_CMD)
        else $error("mode notice on a line that is not CMD");

    // Arming leaves the machine in manual mode.
    a_armed: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && mode_notice == rcd_pkg::NOTE_ARMED |-> flight_mode == rcd_pkg::MODE_MANUAL)
        else $error("armed notice without manual mode");

    // Blocking leaves the machine in block mode.
    a_block: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && mode_notice == rcd_pkg::NOTE_BLOCK |-> flight_mode == rcd_pkg::MODE_BLOCK)
        else $error("block notice without block mode");

endmodule

bind rc_command_line_decoder rcd_checker u_rcd_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_stall    (in_stall),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .line_kind   (line_kind),
    .flight_mode (flight_mode),
    .mode_notice (mode_notice)
);

`default_nettype wire

// ----- dv/rc_command_line_decoder_tb.sv -----
// ----------------------------------------------------------------------------
// rc_command_line_decoder_tb
// Self-checking bench for the command line decoder. A directed table of
// lines runs first, then random well-formed CMD and MOD lines, broken lines
// and noise. Every result word is compared with a behavioral line predictor,
// and several register settings are swept between phases.
// ----------------------------------------------------------------------------
`default_nettype none

module rc_command_line_decoder_tb;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int MAX_LINE    = 64;
    localparam int MAX_TOKENS  = 12;
    localparam int TOKEN_CHARS = 16;
    localparam int WATCHDOG    = 20000;
    localparam int RANDOM_BYTES = 450;

    // Result word as seen at the outputs.
    typedef struct packed {
        logic [2:0]  kind;
        logic [15:0] thr;
        logic [15:0] rol;
        logic [15:0] pit;
        logic [15:0] yw;
        logic        hdg;
        logic [2:0]  mode;
        logic [1:0]  note;
    } line_word_t;

    // One directed row: a line of text, and optionally a typed-in kind.
    typedef struct {
        string          text;
        bit             has_kind;
        rcd_pkg::kind_t kind;
    } dir_row_t;

    logic        clk;
    logic        rst_n;
    logic        cfg_write;
    logic [2:0]  cfg_index;
    logic [15:0] cfg_data;
    logic        in_valid;
    logic        in_stall;
    logic [7:0]  rx_byte;
    logic        out_valid;
    logic        out_stall;
    logic [2:0]  line_kind;
    logic [15:0] thrust;
    logic [15:0] roll;
    logic [15:0] pitch;
    logic [15:0] yaw;
    logic        heading_lock;
    logic [2:0]  flight_mode;
    logic [1:0]  mode_notice;

    rc_command_line_decoder u_top (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_write    (cfg_write),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .rx_byte      (rx_byte),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .line_kind    (line_kind),
        .thrust       (thrust),
        .roll         (roll),
        .pitch        (pitch),
        .yaw          (yaw),
        .heading_lock (heading_lock),
        .flight_mode  (flight_mode),
        .mode_notice  (mode_notice)
    );

    // Predictor state.
    logic [15:0]    p_min, p_max, p_idle, p_arm, p_block;
    int             p_len;
    int             p_tok_num;
    logic [7:0]     p_chars [TOKEN_CHARS];
    int             p_tok_len;
    rcd_pkg::hdr_t  p_hdr;
    rcd_pkg::key_t  p_key;
    logic [15:0]    p_pend [4];
    logic           p_pend_hdg;
    logic [2:0]     p_pend_mode;
    logic [15:0]    p_sticks [4];
    logic           p_hdg;
    logic [2:0]     p_mode;
    bit             p_cut;

    line_word_t     expected_words [$];
    int             errors;
    int             idle_cycles;
    int             lines_seen;
    int             notices_seen;
    bit             quiet;
    bit             check_typed;
    rcd_pkg::kind_t typed_kind;

    // Clock.
    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    function automatic bit tok_matches(string name);
        if (p_tok_len >= TOKEN_CHARS || p_tok_len != name.len())
            return 1'b0;
        for (int i = 0; i < name.len(); i++)
            if (p_chars[i] != name[i])
                return 1'b0;
        return 1'b1;
    endfunction

    // Scans the token as a stick number; returns 1 when in range.
    function automatic bit tok_stick_value(output logic [15:0] val);
        int         i;
        int         mag;
        bit         neg;
        i   = 0;
        mag = 0;
        neg = 1'b0;
        val = '0;
        if (p_tok_len >= TOKEN_CHARS)
            return 1'b0;
        while (i < p_tok_len && (p_chars[i] == 8'd32 || (p_chars[i] >= 8'd9 && p_chars[i] <= 8'd13)))
            i++;
        if (i < p_tok_len && (p_chars[i] == "+" || p_chars[i] == "-"))
        begin
            neg = p_chars[i] == "-";
            i++;
        end
        while (i < p_tok_len && p_chars[i] >= "0" && p_chars[i] <= "9")
        begin
            mag = mag * 10 + (p_chars[i] - "0");
            if (mag > 65535)
                mag = 65535;
            i++;
        end
        if (neg && mag != 0)
            return 1'b0;
        if (mag < p_min || mag > p_max)
            return 1'b0;
        val = 16'(mag);
        return 1'b1;
    endfunction

    function automatic void close_token();
        logic [15:0] v;
        if (p_tok_num < MAX_TOKENS)
        begin
            if (p_tok_num == 0)
            begin
                if (tok_matches("CMD"))      p_hdr = rcd_pkg::HDR_CMD;
                else if (tok_matches("PID")) p_hdr = rcd_pkg::HDR_PID;
                else if (tok_matches("MOD")) p_hdr = rcd_pkg::HDR_MOD;
                else                         p_hdr = rcd_pkg::HDR_UNKNOWN;
            end
            else if (p_hdr == rcd_pkg::HDR_CMD)
            begin
                if (p_tok_num % 2 == 1)
                begin
                    if (tok_matches("T"))      p_key = rcd_pkg::KEY_T;
                    else if (tok_matches("R")) p_key = rcd_pkg::KEY_R;
                    else if (tok_matches("P")) p_key = rcd_pkg::KEY_P;
                    else if (tok_matches("Y")) p_key = rcd_pkg::KEY_Y;
                    else if (tok_matches("H")) p_key = rcd_pkg::KEY_H;
                    else                       p_key = rcd_pkg::KEY_NONE;
                end
                else
                begin
                    if (p_key >= rcd_pkg::KEY_T && p_key <= rcd_pkg::KEY_Y)
                    begin
                        if (tok_stick_value(v))
                            p_pend[int'(p_key) - 1] = v;
                    end
                    else if (p_key == rcd_pkg::KEY_H)
                        p_pend_hdg = (p_tok_len > 0 && p_chars[0] == "T");
                    p_key = rcd_pkg::KEY_NONE;
                end
            end
            else if (p_hdr == rcd_pkg::HDR_MOD && p_tok_num == 1)
            begin
                if (tok_matches("MANUAL"))        p_pend_mode = rcd_pkg::MODE_MANUAL;
                else if (tok_matches("ALTITUDE")) p_pend_mode = rcd_pkg::MODE_ALTITUDE;
                else if (tok_matches("GPS"))      p_pend_mode = rcd_pkg::MODE_GPS;
                else if (tok_matches("HOME"))     p_pend_mode = rcd_pkg::MODE_HOME;
            end
            p_tok_num++;
        end
        p_tok_len = 0;
    endfunction

    function automatic void open_line();
        p_len     = 0;
        p_tok_num = 0;
        p_tok_len = 0;
        p_hdr     = rcd_pkg::HDR_UNKNOWN;
        p_key     = rcd_pkg::KEY_NONE;
        p_pend    = p_sticks;
        p_pend_hdg  = p_hdg;
        p_pend_mode = p_mode;
        p_cut     = 1'b0;
    endfunction

    // Advances the predictor by one accepted byte; queues a word on newline.
    function automatic void predict_byte(logic [7:0] c);
        line_word_t w;
        if (c != rcd_pkg::CH_NEWLINE)
        begin
            if (p_len < MAX_LINE)
                p_len++;
            if (p_cut)
                return;
            if (c == rcd_pkg::CH_NUL)
            begin
                if (p_tok_len > 0)
                    close_token();
                p_cut = 1'b1;
            end
            else if (c == rcd_pkg::CH_COMMA)
            begin
                if (p_tok_len > 0)
                    close_token();
            end
            else if (p_tok_len < TOKEN_CHARS)
            begin
                p_chars[p_tok_len] = c;
                p_tok_len++;
            end
            return;
        end
        if (!p_cut && p_tok_len > 0)
            close_token();
        w.note = rcd_pkg::NOTE_NONE;
        if (p_len == 0 || p_len >= MAX_LINE)
            w.kind = rcd_pkg::KIND_DISCARD;
        else if (p_tok_num == 0 || p_hdr == rcd_pkg::HDR_UNKNOWN)
            w.kind = rcd_pkg::KIND_UNKNOWN;
        else if (p_hdr == rcd_pkg::HDR_PID)
            w.kind = rcd_pkg::KIND_PID;
        else if (p_hdr == rcd_pkg::HDR_MOD)
        begin
            w.kind = rcd_pkg::KIND_MOD;
            p_mode = p_pend_mode;
        end
        else
        begin
            w.kind   = rcd_pkg::KIND_CMD;
            p_sticks = p_pend;
            p_hdg    = p_pend_hdg;
            if (p_sticks[0] < p_idle && p_sticks[3] < p_arm && p_mode == rcd_pkg::MODE_BLOCK)
            begin
                p_mode = rcd_pkg::MODE_MANUAL;
                w.note = rcd_pkg::NOTE_ARMED;
            end
            else if (p_sticks[0] < p_idle && p_sticks[3] > p_block &&
                     p_mode != rcd_pkg::MODE_BLOCK)
            begin
                p_mode = rcd_pkg::MODE_BLOCK;
                w.note = rcd_pkg::NOTE_BLOCK;
            end
        end
        w.thr  = p_sticks[0];
        w.rol  = p_sticks[1];
        w.pit  = p_sticks[2];
        w.yw   = p_sticks[3];
        w.hdg  = p_hdg;
        w.mode = p_mode;
        if (check_typed && w.kind != typed_kind)
        begin
            $error("directed row: kind expected %0d, predicted %0d", typed_kind, w.kind);
            errors++;
        end
        expected_words.push_back(w);
        open_line();
    endfunction

    // Result checking and watchdog, at the rising edge.
    always @(posedge clk)
    begin
        line_word_t e;
        if (rst_n)
        begin
            if ((in_valid && !in_stall) || (out_valid && !out_stall))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= WATCHDOG)
            begin
                $display("watchdog expired with %0d words outstanding", expected_words.size());
                $display("FAIL");
                $finish;
            end
            if (out_valid && !out_stall)
            begin
                lines_seen++;
                if (mode_notice != rcd_pkg::NOTE_NONE)
                    notices_seen++;
                if (expected_words.size() == 0)
                begin
                    $error("result word with no expectation waiting");
                    errors++;
                end
                else
                begin
                    e = expected_words.pop_front();
                    if (line_kind !== e.kind)
                    begin
                        $error("line_kind: expected %0d, actual %0d", e.kind, line_kind);
                        errors++;
                    end
                    if (thrust !== e.thr)
                    begin
                        $error("thrust: expected %0d, actual %0d", e.thr, thrust);
                        errors++;
                    end
                    if (roll !== e.rol)
                    begin
                        $error("roll: expected %0d, actual %0d", e.rol, roll);
                        errors++;
                    end
                    if (pitch !== e.pit)
                    begin
                        $error("pitch: expected %0d, actual %0d", e.pit, pitch);
                        errors++;
                    end
                    if (yaw !== e.yw)
                    begin
                        $error("yaw: expected %0d, actual %0d", e.yw, yaw);
                        errors++;
                    end
                    if (heading_lock !== e.hdg)
                    begin
                        $error("heading_lock: expected %0d, actual %0d", e.hdg, heading_lock);
                        errors++;
                    end
                    if (flight_mode !== e.mode)
                    begin
                        $error("flight_mode: expected %0d, actual %0d", e.mode, flight_mode);
                        errors++;
                    end
                    if (mode_notice !== e.note)
                    begin
                        $error("mode_notice: expected %0d, actual %0d", e.note, mode_notice);
                        errors++;
                    end
                end
            end
        end
    end

    // Output stall bursts, driven at the falling edge.
    initial
    begin
        int gap;
        out_stall = 1'b0;
        forever
        begin
            @(negedge clk);
            if (!quiet && $urandom_range(0, 7) == 0)
            begin
                gap = $urandom_range(1, 11);
                out_stall <= 1'b1;
                repeat (gap) @(negedge clk);
                out_stall <= 1'b0;
            end
        end
    end

    // Sends one byte and waits until it is accepted.
    task automatic send_byte(logic [7:0] c);
        int gap;
        if (!quiet && $urandom_range(0, 9) == 0)
        begin
            gap = $urandom_range(1, 11);
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid <= 1'b1;
        rx_byte  <= c;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        predict_byte(c);
        @(negedge clk);
    endtask

    task automatic send_text(string s);
        for (int i = 0; i < s.len(); i++)
            send_byte(s[i]);
        send_byte(rcd_pkg::CH_NEWLINE);
    endtask

    // Waits for every expected word, then a short drain.
    task automatic drain();
        in_valid <= 1'b0;
        while (expected_words.size() != 0)
            @(negedge clk);
        repeat (4) @(negedge clk);
    endtask

    task automatic write_reg(logic [2:0] idx, logic [15:0] val);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(negedge clk);
        cfg_write <= 1'b0;
        case (idx)
            rcd_pkg::REG_STICK_MIN:   p_min   = val;
            rcd_pkg::REG_STICK_MAX:   p_max   = val;
            rcd_pkg::REG_THRUST_IDLE: p_idle  = val;
            rcd_pkg::REG_YAW_ARM:     p_arm   = val;
            default:                  p_block = val;
        endcase
    endtask

    task automatic write_all(logic [15:0] a, logic [15:0] b, logic [15:0] c,
                             logic [15:0] d, logic [15:0] e);
        write_reg(rcd_pkg::REG_STICK_MIN, a);
        write_reg(rcd_pkg::REG_STICK_MAX, b);
        write_reg(rcd_pkg::REG_THRUST_IDLE, c);
        write_reg(rcd_pkg::REG_YAW_ARM, d);
        write_reg(rcd_pkg::REG_YAW_BLOCK, e);
    endtask

    function automatic string rand_number();
        string s;
        case ($urandom_range(0, 5))
            0:       s = $sformatf("%0d", $urandom_range(0, 65535));
            1:       s = $sformatf("%0d", $urandom_range(0, 999999));
            2:       s = $sformatf(" -%0d", $urandom_range(0, 3));
            3:       s = $sformatf("+%0d", $urandom_range(900, 2100));
            default: s = $sformatf("%0d", $urandom_range(950, 2050));
        endcase
        return s;
    endfunction

    function automatic string rand_cmd_line();
        string s;
        string keys [6];
        keys = '{"T", "R", "P", "Y", "H", "Q"};
        s = "CMD";
        for (int k = $urandom_range(0, 6); k > 0; k--)
        begin
            s = {s, ($urandom_range(0, 5) == 0) ? string'(",,") : string'(","),
                 keys[$urandom_range(0, 5)], ","};
            if ($urandom_range(0, 4) == 0)
                s = {s, ($urandom_range(0, 1) != 0) ? string'("TRUE") : string'("F")};
            else
                s = {s, rand_number()};
        end
        return s;
    endfunction

    function automatic string rand_mod_line();
        string names [6];
        names = '{"MANUAL", "ALTITUDE", "GPS", "HOME", "LOST", "MANUALX"};
        return {"MOD,", names[$urandom_range(0, 5)]};
    endfunction

    dir_row_t rows [$];

    initial
    begin
        int         sent;
        int         pick;
        logic [7:0] b;
        string      s;

        rst_n       = 1'b0;
        cfg_write   = 1'b0;
        cfg_index   = '0;
        cfg_data    = '0;
        in_valid    = 1'b0;
        rx_byte     = '0;
        errors      = 0;
        idle_cycles = 0;
        lines_seen  = 0;
        notices_seen = 0;
        quiet       = 1'b0;
        check_typed = 1'b0;
        typed_kind  = rcd_pkg::KIND_CMD;
        p_min   = 16'd1000;
        p_max   = 16'd2000;
        p_idle  = 16'd1030;
        p_arm   = 16'd1080;
        p_block = 16'd1900;
        for (int i = 0; i < 4; i++)
            p_sticks[i] = '0;
        p_hdg  = 1'b0;
        p_mode = rcd_pkg::MODE_BLOCK;
        for (int i = 0; i < TOKEN_CHARS; i++)
            p_chars[i] = '0;
        open_line();

        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // Directed lines; typed kinds only where they are obvious.
        rows.push_back('{"", 1, rcd_pkg::KIND_DISCARD});
        rows.push_back('{"PID,1,2,3", 1, rcd_pkg::KIND_PID});
        rows.push_back('{"XYZ,1", 1, rcd_pkg::KIND_UNKNOWN});
        rows.push_back('{",,,,", 1, rcd_pkg::KIND_UNKNOWN});
        rows.push_back('{"CMD,T,1000,R,2000,P,999,Y,1050", 1, rcd_pkg::KIND_CMD});
        rows.push_back('{"CMD,T,1020,Y,1950,H,TRUE", 1, rcd_pkg::KIND_CMD});
        rows.push_back('{"MOD,GPS", 1, rcd_pkg::KIND_MOD});
        rows.push_back('{"CMD,T,1010,Y,1995", 1, rcd_pkg::KIND_CMD});
        rows.push_back('{"MOD,ALTITUDE", 1, rcd_pkg::KIND_MOD});
        rows.push_back('{"MOD,HOME", 1, rcd_pkg::KIND_MOD});
        rows.push_back('{"MOD,MANUAL", 1, rcd_pkg::KIND_MOD});
        rows.push_back('{"MOD,BOGUS", 1, rcd_pkg::KIND_MOD});
        rows.push_back('{"CMD,,,R,, \t+1500,P,-0,Y,-5,H,F", 0, rcd_pkg::KIND_CMD});
        rows.push_back('{"CMD,R,99999999,P,1500abc,T,", 0, rcd_pkg::KIND_CMD});
        rows.push_back('{"CMD,R,0000000000001500", 0, rcd_pkg::KIND_CMD});
        rows.push_back('{"CMD,H,TTTTTTTTTTTTTTTTTTTT,Q,1200", 0, rcd_pkg::KIND_CMD});
        rows.push_back('{"CMD,R,1,R,2,R,3,R,4,R,5,P,1400,R,1300", 0, rcd_pkg::KIND_CMD});
        rows.push_back('{"CMDX,T,1000", 1, rcd_pkg::KIND_UNKNOWN});
        rows.push_back('{"CMD,T,1000,Y,1000,R,12345678901234567890123456789012345678901234",
                         1, rcd_pkg::KIND_DISCARD});
        rows.push_back('{"\t", 1, rcd_pkg::KIND_UNKNOWN});
        for (int i = 0; i < rows.size(); i++)
        begin
            check_typed = rows[i].has_kind;
            typed_kind  = rows[i].kind;
            send_text(rows[i].text);
            check_typed = 1'b0;
        end
        // Zero byte cuts the line text; bytes 255 and 128 exercise the top bits.
        send_byte("C"); send_byte("M"); send_byte("D"); send_byte(",");
        send_byte("R"); send_byte(","); send_byte("1"); send_byte("7");
        send_byte("0"); send_byte("0"); send_byte(rcd_pkg::CH_NUL); send_byte(8'd255);
        send_byte(8'd128); send_byte(rcd_pkg::CH_NEWLINE);
        drain();

        // Random phases across several register settings.
        sent = 0;
        for (int phase = 0; phase < 5; phase++)
        begin
            case (phase)
                0: write_all(16'd0, 16'd65535, 16'd65535, 16'd65535, 16'd0);
                1: write_all(16'd65535, 16'd0, 16'd0, 16'd0, 16'd65535);
                2: write_all(16'd1000, 16'd2000, 16'd1030, 16'd1080, 16'd1900);
                3: write_all(16'd950, 16'd2050, 16'd1200, 16'd1300, 16'd1700);
                default: write_all(16'($urandom_range(0, 1200)),
                                   16'($urandom_range(1500, 65535)),
                                   16'($urandom_range(900, 1300)),
                                   16'($urandom_range(900, 1300)),
                                   16'($urandom_range(1600, 2100)));
            endcase
            if (phase == 4)
                quiet = 1'b1;
            while (sent < (phase + 1) * RANDOM_BYTES / 5)
            begin
                pick = $urandom_range(0, 19);
                if (pick < 11)
                    s = rand_cmd_line();
                else if (pick < 14)
                    s = rand_mod_line();
                else if (pick < 15)
                    s = "PID,1.0,2.0";
                else if (pick < 17)
                begin
                    // Noise: random bytes, newline kept out so the line length grows.
                    s = "";
                    for (int k = $urandom_range(0, 70); k > 0; k--)
                    begin
                        b = 8'($urandom_range(0, 255));
                        if (b == rcd_pkg::CH_NEWLINE || b == rcd_pkg::CH_NUL)
                            b = 8'd255;
                        s = {s, string'(b)};
                    end
                end
                else if (pick < 18)
                    s = {rand_cmd_line(), ",T,", rand_number(), ",Y,1000,R,1500,P,1500,Y,1950"};
                else
                begin
                    // Broken line: a zero byte partway.
                    for (int k = 0; k < 6; k++)
                        send_byte(8'($urandom_range(1, 255) == 10 ? 65 : $urandom_range(1, 255)));
                    send_byte(rcd_pkg::CH_NUL);
                    sent += 7;
                    s = "CMD,T,1000";
                end
                send_text(s);
                sent += s.len() + 1;
            end
            drain();
        end

        $display("Decoded %0d lines over five register settings, %0d with a mode notice.",
                 lines_seen, notices_seen);
        if (errors == 0 && expected_words.size() == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule

`default_nettype wire
